// ===== sv/uvc_pkg.sv =====
// Shared types and constants for the unsigned varint codec.
// Used by the encoder, the decoder and the top level; depends on nothing.
package uvc_pkg;

	localparam int NUM_W   = 64;  // width of a number to encode
	localparam int VALUE_W = 56;  // width of the decode accumulator
	localparam int GROUP_W = 7;   // payload bits per varint byte
	localparam int BYTE_W  = 8;
	localparam int LANES   = VALUE_W / GROUP_W;
	localparam int COUNT_W = 4;   // byte counters, enough for ten bytes

	// Command carried by one input transaction
	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Kind of one result transaction
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// One result transaction as it moves toward the output register
	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   data;
		logic                last;
		logic [VALUE_W-1:0]  value;
	} result_t;

endpackage

// ===== sv/uvc_encoder.sv =====
// Varint encoder: shift register that emits one 7-bit group per cycle while slot_ok is high.
// Depends on uvc_pkg for the result type and field widths.
module uvc_encoder #(
	parameter int MAX_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [uvc_pkg::NUM_W-1:0]    number,
	input  logic                         slot_ok,
	output logic                         busy,
	output logic                         res_valid,
	output uvc_pkg::result_t             res
);

	localparam int CAP_BITS = uvc_pkg::GROUP_W * MAX_BYTES;
	localparam logic [uvc_pkg::NUM_W-1:0] HIGH_MASK = (CAP_BITS >= uvc_pkg::NUM_W) ? '0 :
		~((64'd1 << CAP_BITS) - 64'd1);
	localparam logic [uvc_pkg::COUNT_W-1:0] LAST_K = uvc_pkg::COUNT_W'(MAX_BYTES - 1);

	logic [uvc_pkg::NUM_W-1:0]   rem_q;
	logic [uvc_pkg::COUNT_W-1:0] k_q;
	logic                        busy_q;

	logic [uvc_pkg::NUM_W-1:0]   src;
	logic [uvc_pkg::NUM_W-1:0]   nxt;
	logic [uvc_pkg::COUNT_W-1:0] k_cur;
	logic                        emit;
	logic                        too_wide;
	logic                        final_group;

	// Pick the fresh number on start, else the remaining groups
	always_comb begin
		src         = busy_q ? rem_q : number;
		k_cur       = busy_q ? k_q : '0;
		nxt         = src >> uvc_pkg::GROUP_W;
		emit        = (start || busy_q) && slot_ok;
		too_wide    = start && !busy_q && ((number & HIGH_MASK) != '0);
		final_group = (nxt == '0) || (k_cur == LAST_K);
	end

	// Build the result for this cycle
	always_comb begin
		res = '0;
		if (too_wide) begin
			res.kind = uvc_pkg::KIND_ERROR;
			res.last = 1'b1;
		end else begin
			res.kind = uvc_pkg::KIND_BYTE;
			res.data = {!final_group, src[uvc_pkg::GROUP_W-1:0]};
			res.last = final_group;
		end
	end

	assign res_valid = emit;
	assign busy      = busy_q;

	// Advance the shift register by one group per emitted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (emit) begin
			if (too_wide || final_group) begin
				busy_q <= 1'b0;
				k_q    <= '0;
			end else begin
				busy_q <= 1'b1;
				k_q    <= k_cur + uvc_pkg::COUNT_W'(1);
			end
		end
	end

	// Hold the remaining groups; payload needs no reset
	always_ff @(posedge clk) begin
		if (emit) begin
			rem_q <= nxt;
		end
	end

endmodule

// ===== sv/uvc_decoder.sv =====
// Varint decoder: one byte per transaction into one 7-bit lane of the accumulator.
// Depends on uvc_pkg for the result type and field widths.
module uvc_decoder #(
	parameter int MAX_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [uvc_pkg::BYTE_W-1:0]    byte_in,
	output logic                          res_valid,
	output uvc_pkg::result_t              res
);

	localparam logic [uvc_pkg::COUNT_W-1:0] MAX_COUNT = uvc_pkg::COUNT_W'(MAX_BYTES);

	logic [uvc_pkg::LANES-1:0][uvc_pkg::GROUP_W-1:0] acc_q;
	logic [uvc_pkg::COUNT_W-1:0]                     count_q;

	logic [uvc_pkg::LANES-1:0][uvc_pkg::GROUP_W-1:0] acc_n;
	logic [uvc_pkg::COUNT_W-1:0]                     count_inc;
	logic                                            done;
	logic                                            overrun;

	// OR the new group into the lane picked by the byte count; beyond the lanes drop it
	always_comb begin
		for (int i = 0; i < uvc_pkg::LANES; i++) begin
			acc_n[i] = acc_q[i];
			if (count_q == uvc_pkg::COUNT_W'(i)) begin
				acc_n[i] = acc_q[i] | byte_in[uvc_pkg::GROUP_W-1:0];
			end
		end
		count_inc = count_q + uvc_pkg::COUNT_W'(1);
		done      = start && !byte_in[uvc_pkg::BYTE_W-1];
		overrun   = start && byte_in[uvc_pkg::BYTE_W-1] && (count_inc >= MAX_COUNT);
	end

	// Report a finished value or a too-long error
	always_comb begin
		res      = '0;
		res.last = 1'b1;
		if (done) begin
			res.kind  = uvc_pkg::KIND_VALUE;
			res.value = acc_n;
		end else begin
			res.kind = uvc_pkg::KIND_ERROR;
		end
	end

	assign res_valid = done || overrun;

	// Gather or clear the decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
		end else if (start) begin
			if (done || overrun) begin
				acc_q   <= '0;
				count_q <= '0;
			end else begin
				acc_q   <= acc_n;
				count_q <= count_inc;
			end
		end
	end

endmodule

// ===== sv/unsigned_varint_codec.sv =====
// Top level of the unsigned varint codec: input handshake, output register.
// Depends on uvc_pkg, uvc_encoder and uvc_decoder.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | command, number, byte_in
//   output  | out       | out_valid/out_stall| result_kind, out_byte, last, decoded
//
// Encode: 1 to MAX_BYTES output bytes from the encoder shift register, which sends
//   one 7-bit group per cycle unless out_stall holds the output; too wide: one error result.
// Decode: one byte per input transaction, a result only on the final byte or an overrun.
// Reset clears the decode accumulator, byte count and control; no clearing pass.
// in_stall is high while the encoder has bytes left or the output register is
// full and stalled; out_stall freezes the output register and the encoder.
module unsigned_varint_codec #(
	parameter int MAX_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [uvc_pkg::NUM_W-1:0]     number,
	input  logic [uvc_pkg::BYTE_W-1:0]    byte_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic [uvc_pkg::BYTE_W-1:0]    out_byte,
	output logic                          last,
	output logic [uvc_pkg::VALUE_W-1:0]   decoded
);

	logic             out_valid_q;
	uvc_pkg::result_t out_q;

	logic             slot_ok;
	logic             in_accept;
	logic             enc_start;
	logic             dec_start;
	logic             enc_busy;
	logic             enc_res_valid;
	logic             dec_res_valid;
	uvc_pkg::result_t enc_res;
	uvc_pkg::result_t dec_res;

	// Accept a transaction when the encoder is idle and the output slot frees up
	assign slot_ok   = !out_valid_q || !out_stall;
	assign in_stall  = enc_busy || !slot_ok;
	assign in_accept = in_valid && !in_stall;
	assign enc_start = in_accept && (command == uvc_pkg::CMD_ENCODE);
	assign dec_start = in_accept && (command == uvc_pkg::CMD_DECODE);

	uvc_encoder #(
		.MAX_BYTES (MAX_BYTES)
	) u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (enc_start),
		.number    (number),
		.slot_ok   (slot_ok),
		.busy      (enc_busy),
		.res_valid (enc_res_valid),
		.res       (enc_res)
	);

	uvc_decoder #(
		.MAX_BYTES (MAX_BYTES)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (dec_start),
		.byte_in   (byte_in),
		.res_valid (dec_res_valid),
		.res       (dec_res)
	);

	// Output register valid: load a new result or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_ok) begin
			out_valid_q <= enc_res_valid || dec_res_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (slot_ok && (enc_res_valid || dec_res_valid)) begin
			out_q <= enc_res_valid ? enc_res : dec_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_q.kind;
	assign out_byte    = out_q.data;
	assign last        = out_q.last;
	assign decoded     = out_q.value;

	// Encoder and decoder never produce a result in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(enc_res_valid && dec_res_valid))
		else $error("encoder and decoder results collide");

	// A stalled result stays in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result dropped");

	// A non-final encoded byte leaves the encoder busy with the rest
	assert property (@(posedge clk) disable iff (!arst_n)
		enc_res_valid && slot_ok && !enc_res.last |=> enc_busy)
		else $error("encoder stopped before its final byte");

	// Continuation bit of an encoded byte is set exactly when it is not the last
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == uvc_pkg::KIND_BYTE) |-> (out_q.data[7] != out_q.last))
		else $error("continuation bit disagrees with last");

endmodule
